/* rtl/etpm_pkg.sv */
package etpm_pkg;

  // Default number of polynomial coefficients per curve.
  localparam int COEFF_COUNT_DEF = 5;

  // Standard gravity in micro metres per second squared.
  localparam logic [23:0] GRAVITY_MICRO = 24'd9806650;

  // Field and datapath widths.
  localparam int PW       = 24;  // power, Q8.16 kW
  localparam int CW       = 32;  // coefficients and result values
  localparam int QW       = 33;  // quotient bits kept by the dividers
  localparam int ISPG_W   = 40;  // Isp times gravity
  localparam int ISPG2_W  = 80;  // square of Isp times gravity
  localparam int NUMA_W   = 66;  // numerator of the single divider
  localparam int NUMB_W   = 96;  // numerator of the squared divider

  typedef logic signed [CW-1:0] coef_t;

  localparam coef_t SAT_MAX = 32'sh7FFF_FFFF;
  localparam coef_t SAT_MIN = 32'sh8000_0000;

  // Input item kinds.
  typedef enum logic {
    CMD_EVAL = 1'b0,
    CMD_LOAD = 1'b1
  } cmd_t;

  // Thrust model codes; any other code is fixed efficiency.
  localparam logic [1:0] MODEL_POLY  = 2'd0;
  localparam logic [1:0] MODEL_CONST = 2'd1;

  // Configuration register indexes.
  localparam logic [2:0] CFG_THRUST_MODEL    = 3'd0;
  localparam logic [2:0] CFG_MAX_POWER       = 3'd1;
  localparam logic [2:0] CFG_MIN_POWER       = 3'd2;
  localparam logic [2:0] CFG_EFFICIENCY      = 3'd3;
  localparam logic [2:0] CFG_ISP             = 3'd4;
  localparam logic [2:0] CFG_CONST_THRUST    = 3'd5;
  localparam logic [2:0] CFG_DUTY_CYCLE      = 3'd6;
  localparam logic [2:0] CFG_THRUST_SCALE    = 3'd7;

  // Reset values of the configuration registers.
  localparam logic [1:0]  RST_THRUST_MODEL = 2'd0;
  localparam logic [23:0] RST_MAX_POWER    = 24'd476185;
  localparam logic [23:0] RST_MIN_POWER    = 24'd41812;
  localparam logic [15:0] RST_EFFICIENCY   = 16'd45875;
  localparam logic [15:0] RST_ISP          = 16'd4200;
  localparam logic [30:0] RST_CONST_THRUST = 31'd15532032;
  localparam logic [16:0] RST_DUTY_CYCLE   = 17'd65536;
  localparam logic [23:0] RST_THRUST_SCALE = 24'd65536;

  // Default curve coefficients, c0 first.
  localparam coef_t THRUST_DEF [5] = '{-32'sd340186, 32'sd194327, -32'sd948889,
                                       32'sd3542471, -32'sd66};
  localparam coef_t FLOW_DEF [5]   = '{-32'sd313, 32'sd3747, -32'sd6525,
                                       32'sd2104, 32'sd140104};

  // Control flags that travel beside the data.
  typedef struct packed {
    logic valid;
    logic zero;
    logic below;
    logic clamped;
  } ctl_t;

  // Reset value of one word of the coefficient table.
  function automatic coef_t coef_reset(input int idx, input int cc);
    coef_t v;
    int    j;
    v = '0;
    j = (idx < cc) ? idx : idx - cc;
    if (j < 5) begin
      v = (idx < cc) ? THRUST_DEF[j] : FLOW_DEF[j];
    end
    return v;
  endfunction

  // Turns twice the quotient into a rounded, saturated value.
  function automatic coef_t finish_round(input logic [QW-1:0] q2, input logic sat);
    logic [QW-1:0] v;
    v = (q2 >> 1) + QW'(q2[0]);
    if (sat || v > QW'(SAT_MAX)) begin
      return SAT_MAX;
    end
    return coef_t'(v[CW-1:0]);
  endfunction

endpackage

/* rtl/etpm_horner_cell.sv */
module etpm_horner_cell #(
  parameter int COEFF_COUNT = etpm_pkg::COEFF_COUNT_DEF,
  parameter int STEP        = 0
) (
  input  logic                    clk,
  input  logic                    en,
  input  logic [etpm_pkg::PW-1:0] p_i,
  input  etpm_pkg::coef_t         acc_t_i,
  input  etpm_pkg::coef_t         acc_f_i,
  input  etpm_pkg::coef_t         tab_i [2*COEFF_COUNT],
  output logic [etpm_pkg::PW-1:0] p_o,
  output etpm_pkg::coef_t         acc_t_o,
  output etpm_pkg::coef_t         acc_f_o,
  output etpm_pkg::coef_t         tab_o [2*COEFF_COUNT]
);

  localparam int IDX = COEFF_COUNT - 2 - STEP;

  // One Horner step: round(acc * p / 2^16) + c, saturated.
  function automatic etpm_pkg::coef_t step(input etpm_pkg::coef_t acc,
                                           input logic [etpm_pkg::PW-1:0] p,
                                           input etpm_pkg::coef_t c);
    logic [31:0]        mag;
    logic [55:0]        prod;
    logic [39:0]        r;
    logic signed [41:0] rs;
    logic signed [41:0] sum;
    mag  = acc[31] ? (~acc + 32'd1) : acc;
    prod = 56'(mag) * 56'(p) + 56'd32768;
    r    = prod[55:16];
    rs   = acc[31] ? -$signed({2'b00, r}) : $signed({2'b00, r});
    sum  = rs + 42'(c);
    if (sum > 42'(etpm_pkg::SAT_MAX)) begin
      return etpm_pkg::SAT_MAX;
    end
    if (sum < 42'(etpm_pkg::SAT_MIN)) begin
      return etpm_pkg::SAT_MIN;
    end
    return etpm_pkg::coef_t'(sum[31:0]);
  endfunction

  // Both curves advance one coefficient; the table snapshot moves along.
  always_ff @(posedge clk) begin
    if (en) begin
      p_o     <= p_i;
      acc_t_o <= step(acc_t_i, p_i, tab_i[IDX]);
      acc_f_o <= step(acc_f_i, p_i, tab_i[COEFF_COUNT + IDX]);
      tab_o   <= tab_i;
    end
  end

endmodule

/* rtl/etpm_div_cell.sv */
module etpm_div_cell #(
  parameter int DW  = 40,
  parameter int BIT = 0
) (
  input  logic                    clk,
  input  logic                    en,
  input  logic [DW-1:0]           d_i,
  input  logic [etpm_pkg::QW-1:0] num_i,
  input  logic [DW-1:0]           rem_i,
  input  logic [etpm_pkg::QW-1:0] q_i,
  input  logic                    sat_i,
  output logic [etpm_pkg::QW-1:0] num_o,
  output logic [DW-1:0]           rem_o,
  output logic [etpm_pkg::QW-1:0] q_o,
  output logic                    sat_o
);

  logic [DW:0]               trial;
  logic [DW:0]               diff;
  logic                      ge;
  logic [etpm_pkg::QW-1:0]   q_nxt;

  // Restoring step: bring in one numerator bit and try the subtraction.
  assign trial = {rem_i, num_i[BIT]};
  assign diff  = trial - {1'b0, d_i};
  assign ge    = trial >= {1'b0, d_i};

  // The quotient so far with this cell's bit filled in.
  always_comb begin
    q_nxt      = q_i;
    q_nxt[BIT] = ge;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num_o      <= num_i;
      rem_o      <= ge ? diff[DW-1:0] : trial[DW-1:0];
      q_o        <= q_nxt;
      sat_o      <= sat_i;
    end
  end

endmodule

/* rtl/etpm_div_chain.sv */
module etpm_div_chain #(
  parameter int NW = etpm_pkg::NUMA_W,
  parameter int DW = etpm_pkg::ISPG_W
) (
  input  logic                    clk,
  input  logic                    en,
  input  logic [NW-1:0]           num_i,
  input  logic [DW-1:0]           d_i,
  output logic [etpm_pkg::QW-1:0] q_o,
  output logic                    sat_o
);

  localparam int QW = etpm_pkg::QW;
  localparam int HW = NW - QW;
  localparam int MW = (HW > DW) ? HW : DW;

  logic [MW-1:0] hi_x;
  logic [MW-1:0] d_x;

  logic [QW-1:0] num_w [QW+1];
  logic [DW-1:0] rem_w [QW+1];
  logic [QW-1:0] q_w   [QW+1];
  logic          sat_w [QW+1];

  assign hi_x = MW'(num_i[NW-1:QW]);
  assign d_x  = MW'(d_i);

  // Head stage: a quotient that needs more than QW bits saturates, and so
  // does a zero divisor.
  always_ff @(posedge clk) begin
    if (en) begin
      num_w[0] <= num_i[QW-1:0];
      rem_w[0] <= hi_x[DW-1:0];
      sat_w[0] <= hi_x >= d_x;
    end
  end

  assign q_w[0] = '0;

  // One quotient bit per cell, most significant first.
  for (genvar k = 0; k < QW; k++) begin : g_cell
    etpm_div_cell #(
      .DW  (DW),
      .BIT (QW - 1 - k)
    ) u_cell (
      .clk   (clk),
      .en    (en),
      .d_i   (d_i),
      .num_i (num_w[k]),
      .rem_i (rem_w[k]),
      .q_i   (q_w[k]),
      .sat_i (sat_w[k]),
      .num_o (num_w[k+1]),
      .rem_o (rem_w[k+1]),
      .q_o   (q_w[k+1]),
      .sat_o (sat_w[k+1])
    );
  end

  assign q_o   = q_w[QW];
  assign sat_o = sat_w[QW];

endmodule

/* rtl/electric_thruster_power_model.sv */
// Throughput: one request per cycle; a load request takes effect at once and gives no result.
// The two 33-cell division chains give one quotient bit per cell.
// The whole pipeline stalls only while a result waits at the output.
// Reset (rst_n, synchronous, active low) restores registers and default coefficients.
module electric_thruster_power_model #(
  parameter int COEFF_COUNT = etpm_pkg::COEFF_COUNT_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // power_in[23:0], firing[24], coeff_index[28:25], coeff_value[60:29], zeros
  input  logic [63:0]  in_tdata,
  // command[0]
  input  logic         in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // thrust_mn[31:0], applied_thrust_mn[63:32], mass_flow[95:64],
  // below_minimum[96], power_clamped[97], zeros
  output logic [103:0] out_tdata,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_addr,
  input  logic [30:0]  cfg_wdata
);

  localparam int TBL      = 2 * COEFF_COUNT;
  localparam int QW       = etpm_pkg::QW;
  localparam int DIV_IN   = 5;
  localparam int DIV_OUT  = DIV_IN + QW + 1;
  localparam int HD       = DIV_OUT - (COEFF_COUNT - 1);

  // Configuration registers.
  logic [1:0]  thrust_model_r;
  logic [23:0] max_power_r;
  logic [23:0] min_power_r;
  logic [15:0] efficiency_r;
  logic [15:0] isp_r;
  logic [30:0] const_thrust_r;
  logic [16:0] duty_cycle_r;
  logic [23:0] thrust_scale_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thrust_model_r <= etpm_pkg::RST_THRUST_MODEL;
      max_power_r    <= etpm_pkg::RST_MAX_POWER;
      min_power_r    <= etpm_pkg::RST_MIN_POWER;
      efficiency_r   <= etpm_pkg::RST_EFFICIENCY;
      isp_r          <= etpm_pkg::RST_ISP;
      const_thrust_r <= etpm_pkg::RST_CONST_THRUST;
      duty_cycle_r   <= etpm_pkg::RST_DUTY_CYCLE;
      thrust_scale_r <= etpm_pkg::RST_THRUST_SCALE;
    end else if (cfg_we) begin
      case (cfg_addr)
        etpm_pkg::CFG_THRUST_MODEL: thrust_model_r <= cfg_wdata[1:0];
        etpm_pkg::CFG_MAX_POWER:    max_power_r    <= cfg_wdata[23:0];
        etpm_pkg::CFG_MIN_POWER:    min_power_r    <= cfg_wdata[23:0];
        etpm_pkg::CFG_EFFICIENCY:   efficiency_r   <= cfg_wdata[15:0];
        etpm_pkg::CFG_ISP:          isp_r          <= cfg_wdata[15:0];
        etpm_pkg::CFG_CONST_THRUST: const_thrust_r <= cfg_wdata;
        etpm_pkg::CFG_DUTY_CYCLE:   duty_cycle_r   <= cfg_wdata[16:0];
        etpm_pkg::CFG_THRUST_SCALE: thrust_scale_r <= cfg_wdata[23:0];
        default: ;
      endcase
    end
  end

  // Constants derived from the configuration; they settle well before any
  // request reaches the dividers.
  logic [etpm_pkg::ISPG_W-1:0]  ispg_r;
  logic [39:0]                  sq_hh_r;
  logic [39:0]                  sq_hl_r;
  logic [39:0]                  sq_ll_r;
  logic [etpm_pkg::ISPG2_W-1:0] ispg2_r;
  logic [61:0]                  ct2_r;

  always_ff @(posedge clk) begin
    ispg_r  <= 40'(isp_r) * 40'(etpm_pkg::GRAVITY_MICRO);
    sq_hh_r <= 40'(ispg_r[39:20]) * 40'(ispg_r[39:20]);
    sq_hl_r <= 40'(ispg_r[39:20]) * 40'(ispg_r[19:0]);
    sq_ll_r <= 40'(ispg_r[19:0]) * 40'(ispg_r[19:0]);
    ispg2_r <= (80'(sq_hh_r) << 40) + (80'(sq_hl_r) << 21) + 80'(sq_ll_r);
    ct2_r   <= 62'(const_thrust_r) * 62'd2000000000;
  end

  // Handshake and input fields.
  logic        out_valid_r;
  logic        en;
  logic        accept;
  logic [23:0] power_in;
  logic        firing;
  logic [3:0]  coeff_index;
  etpm_pkg::coef_t coeff_value;

  assign en          = !out_valid_r || out_tready;
  assign in_tready   = en;
  assign accept      = in_tvalid && en;
  assign power_in    = in_tdata[23:0];
  assign firing      = in_tdata[24];
  assign coeff_index = in_tdata[28:25];
  assign coeff_value = etpm_pkg::coef_t'(in_tdata[60:29]);

  // Coefficient table; a load beyond the table is dropped.
  etpm_pkg::coef_t coef_r [TBL];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < TBL; i++) begin
        coef_r[i] <= etpm_pkg::coef_reset(i, COEFF_COUNT);
      end
    end else if (accept && in_tuser == etpm_pkg::CMD_LOAD) begin
      for (int i = 0; i < TBL; i++) begin
        if (coeff_index == 4'(i)) begin
          coef_r[i] <= coeff_value;
        end
      end
    end
  end

  // Minimum test first, then the clamp to the maximum.
  logic          below0;
  logic          active0;
  logic          clamp0;
  logic [23:0]   p0;
  etpm_pkg::ctl_t ctl0;

  assign below0  = firing && (power_in < min_power_r);
  assign active0 = firing && !below0;
  assign clamp0  = active0 && (power_in > max_power_r);
  assign p0      = clamp0 ? max_power_r : power_in;

  always_comb begin
    ctl0.valid   = accept && in_tuser == etpm_pkg::CMD_EVAL;
    ctl0.zero    = !active0;
    ctl0.below   = below0;
    ctl0.clamped = clamp0;
  end

  // Control flags up to the division outputs.
  etpm_pkg::ctl_t ctl_r [DIV_OUT];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DIV_OUT; i++) begin
        ctl_r[i] <= '0;
      end
    end else if (en) begin
      ctl_r[0] <= ctl0;
      for (int i = 1; i < DIV_OUT; i++) begin
        ctl_r[i] <= ctl_r[i-1];
      end
    end
  end

  // Horner chain, one coefficient per cell.
  logic [23:0]     hp_w   [COEFF_COUNT];
  etpm_pkg::coef_t ht_w   [COEFF_COUNT];
  etpm_pkg::coef_t hf_w   [COEFF_COUNT];
  etpm_pkg::coef_t htab_w [COEFF_COUNT][TBL];

  assign hp_w[0]   = p0;
  assign ht_w[0]   = coef_r[COEFF_COUNT-1];
  assign hf_w[0]   = coef_r[TBL-1];
  assign htab_w[0] = coef_r;

  for (genvar k = 0; k < COEFF_COUNT - 1; k++) begin : g_horner
    etpm_horner_cell #(
      .COEFF_COUNT (COEFF_COUNT),
      .STEP        (k)
    ) u_cell (
      .clk     (clk),
      .en      (en),
      .p_i     (hp_w[k]),
      .acc_t_i (ht_w[k]),
      .acc_f_i (hf_w[k]),
      .tab_i   (htab_w[k]),
      .p_o     (hp_w[k+1]),
      .acc_t_o (ht_w[k+1]),
      .acc_f_o (hf_w[k+1]),
      .tab_o   (htab_w[k+1])
    );
  end

  // Polynomial results wait for the division chains.
  etpm_pkg::coef_t hdt_r [HD];
  etpm_pkg::coef_t hdf_r [HD];

  always_ff @(posedge clk) begin
    if (en) begin
      hdt_r[0] <= ht_w[COEFF_COUNT-1];
      hdf_r[0] <= hf_w[COEFF_COUNT-1];
      for (int i = 1; i < HD; i++) begin
        hdt_r[i] <= hdt_r[i-1];
        hdf_r[i] <= hdf_r[i-1];
      end
    end
  end

  // Numerators: eff*P*1e12/2^14 and eff*P*1e21/2^14, or constant thrust*2e9.
  logic [39:0]                 m1_r;
  logic [59:0]                 tlo2_r;
  logic [59:0]                 thi2_r;
  logic [79:0]                 t3_r;
  logic [56:0]                 u0_r;
  logic [56:0]                 u1_r;
  logic [56:0]                 u2_r;
  logic [etpm_pkg::NUMA_W-1:0] numa4_r;
  logic [etpm_pkg::NUMA_W-1:0] numa5_r;
  logic [etpm_pkg::NUMB_W-1:0] numb5_r;
  logic [109:0]                u5;

  assign u5 = 110'(u0_r) + (110'(u1_r) << 27) + (110'(u2_r) << 54);

  always_ff @(posedge clk) begin
    if (en) begin
      m1_r    <= 40'(efficiency_r) * 40'(p0);
      tlo2_r  <= 60'(m1_r[19:0]) * 60'd1000000000000;
      thi2_r  <= 60'(m1_r[39:20]) * 60'd1000000000000;
      t3_r    <= 80'(tlo2_r) + (80'(thi2_r) << 20);
      u0_r    <= 57'(t3_r[26:0]) * 57'd1000000000;
      u1_r    <= 57'(t3_r[53:27]) * 57'd1000000000;
      u2_r    <= 57'(t3_r[79:54]) * 57'd1000000000;
      numa4_r <= (thrust_model_r == etpm_pkg::MODEL_CONST) ? 66'(ct2_r) : t3_r[79:14];
      numa5_r <= numa4_r;
      numb5_r <= u5[109:14];
    end
  end

  // Division by Isp*G and by (Isp*G)^2.
  logic [QW-1:0] qa;
  logic [QW-1:0] qb;
  logic          sata;
  logic          satb;

  etpm_div_chain #(
    .NW (etpm_pkg::NUMA_W),
    .DW (etpm_pkg::ISPG_W)
  ) u_div_a (
    .clk   (clk),
    .en    (en),
    .num_i (numa5_r),
    .d_i   (ispg_r),
    .q_o   (qa),
    .sat_o (sata)
  );

  etpm_div_chain #(
    .NW (etpm_pkg::NUMB_W),
    .DW (etpm_pkg::ISPG2_W)
  ) u_div_b (
    .clk   (clk),
    .en    (en),
    .num_i (numb5_r),
    .d_i   (ispg2_r),
    .q_o   (qb),
    .sat_o (satb)
  );

  // Model selection.
  etpm_pkg::ctl_t  cfin;
  etpm_pkg::coef_t th_sel;
  etpm_pkg::coef_t fl_sel;

  assign cfin = ctl_r[DIV_OUT-1];

  always_comb begin
    case (thrust_model_r)
      etpm_pkg::MODEL_POLY: begin
        th_sel = hdt_r[HD-1];
        fl_sel = hdf_r[HD-1];
      end
      etpm_pkg::MODEL_CONST: begin
        th_sel = etpm_pkg::coef_t'({1'b0, const_thrust_r});
        fl_sel = etpm_pkg::finish_round(qa, sata);
      end
      default: begin
        th_sel = etpm_pkg::finish_round(qa, sata);
        fl_sel = etpm_pkg::finish_round(qb, satb);
      end
    endcase
    if (cfin.zero) begin
      th_sel = '0;
      fl_sel = '0;
    end
  end

  logic            v40_r;
  logic            v41_r;
  logic            v42_r;
  logic            below40_r;
  logic            below41_r;
  logic            below42_r;
  logic            clamp40_r;
  logic            clamp41_r;
  logic            clamp42_r;
  etpm_pkg::coef_t th40_r;
  etpm_pkg::coef_t fl40_r;
  etpm_pkg::coef_t th41_r;
  etpm_pkg::coef_t th42_r;
  etpm_pkg::coef_t mf41_r;
  etpm_pkg::coef_t mf42_r;
  logic [55:0]     amag41_r;
  logic            neg41_r;
  logic            neg42_r;
  logic [44:0]     plo42_r;
  logic [44:0]     phi42_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v40_r <= 1'b0;
      v41_r <= 1'b0;
      v42_r <= 1'b0;
    end else if (en) begin
      v40_r <= cfin.valid;
      v41_r <= v40_r;
      v42_r <= v41_r;
    end
  end

  // Scaled mass flow: -round(flow * duty / 2^16), saturated.
  logic [31:0]        thmag;
  logic [31:0]        flmag;
  logic [48:0]        fprod;
  logic [32:0]        fr;
  logic signed [34:0] fneg;
  etpm_pkg::coef_t    mf_nxt;

  assign thmag = th40_r[31] ? (~th40_r + 32'd1) : th40_r;
  assign flmag = fl40_r[31] ? (~fl40_r + 32'd1) : fl40_r;
  assign fprod = 49'(flmag) * 49'(duty_cycle_r) + 49'd32768;
  assign fr    = fprod[48:16];
  assign fneg  = fl40_r[31] ? $signed({2'b00, fr}) : -$signed({2'b00, fr});

  always_comb begin
    if (fneg > 35'(etpm_pkg::SAT_MAX)) begin
      mf_nxt = etpm_pkg::SAT_MAX;
    end else if (fneg < 35'(etpm_pkg::SAT_MIN)) begin
      mf_nxt = etpm_pkg::SAT_MIN;
    end else begin
      mf_nxt = etpm_pkg::coef_t'(fneg[31:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      below40_r <= cfin.below;
      clamp40_r <= cfin.clamped;
      th40_r    <= th_sel;
      fl40_r    <= fl_sel;

      below41_r <= below40_r;
      clamp41_r <= clamp40_r;
      th41_r    <= th40_r;
      mf41_r    <= mf_nxt;
      neg41_r   <= th40_r[31];
      amag41_r  <= 56'(thmag) * 56'(thrust_scale_r);

      below42_r <= below41_r;
      clamp42_r <= clamp41_r;
      th42_r    <= th41_r;
      mf42_r    <= mf41_r;
      neg42_r   <= neg41_r;
      plo42_r   <= 45'(amag41_r[27:0]) * 45'(duty_cycle_r);
      phi42_r   <= 45'(amag41_r[55:28]) * 45'(duty_cycle_r);
    end
  end

  // Applied thrust: round(|thrust| * scale * duty / 2^32), signed, saturated.
  logic [73:0]     wsum;
  logic [41:0]     ar;
  logic [31:0]     arc;
  etpm_pkg::coef_t app_nxt;

  assign wsum = 74'(plo42_r) + (74'(phi42_r) << 28) + 74'h8000_0000;
  assign ar   = wsum[73:32];
  assign arc  = (ar > 42'h8000_0000) ? 32'h8000_0000 : ar[31:0];

  always_comb begin
    if (neg42_r) begin
      app_nxt = etpm_pkg::coef_t'(~arc + 32'd1);
    end else if (arc[31]) begin
      app_nxt = etpm_pkg::SAT_MAX;
    end else begin
      app_nxt = etpm_pkg::coef_t'(arc);
    end
  end

  // Output register.
  etpm_pkg::coef_t out_thrust_r;
  etpm_pkg::coef_t out_applied_r;
  etpm_pkg::coef_t out_flow_r;
  logic            out_below_r;
  logic            out_clamp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= v42_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_thrust_r  <= th42_r;
      out_applied_r <= app_nxt;
      out_flow_r    <= mf42_r;
      out_below_r   <= below42_r;
      out_clamp_r   <= clamp42_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'b0, out_clamp_r, out_below_r, out_flow_r, out_applied_r,
                       out_thrust_r};

`ifndef SYNTHESIS
  // A result is never both below the minimum and clamped.
  a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_below_r && out_clamp_r))
    else $error("below_minimum and power_clamped both set");

  // Below the minimum every value is zero.
  a_below_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_below_r) |->
      (out_thrust_r == '0 && out_applied_r == '0 && out_flow_r == '0))
    else $error("non-zero values below minimum power");

  // A load request never enters the result pipeline.
  a_load_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_tuser == etpm_pkg::CMD_LOAD) |=> !ctl_r[0].valid)
    else $error("load request produced a result");

  // An evaluate request that is not firing is forced to zero.
  a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_tuser == etpm_pkg::CMD_EVAL && !firing) |=>
      (ctl_r[0].valid && ctl_r[0].zero && !ctl_r[0].below))
    else $error("non-firing request not forced to zero");
`endif

endmodule
